FILE: hw/rtl/bcdt_pkg.sv
// bcdt_pkg: shared types, command and function codes, and helper functions
// for the BCD clock / timer / stopwatch. No dependencies.
package bcdt_pkg;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_LOAD    = 3'd1;
	localparam logic [2:0] MODE_CLEAR   = 3'd2;
	localparam logic [2:0] MODE_RUN     = 3'd3;
	localparam logic [2:0] MODE_SILENCE = 3'd4;

	localparam logic [1:0] FN_CLOCK     = 2'd0;
	localparam logic [1:0] FN_STOPWATCH = 2'd1;
	localparam logic [1:0] FN_TIMER     = 2'd2;

	localparam int NumDigits = 6;
	localparam logic [16:0] SecsPerDay = 17'd86400;
	localparam logic [4:0] MaxHours = 5'd23;
	localparam logic [5:0] MaxMinSec = 6'd59;

	typedef logic [3:0] digit_t;
	typedef digit_t [NumDigits-1:0] digits_t;

	// order: sec ones, sec tens, min ones, min tens, hour ones, hour tens
	localparam digits_t DigitLimit = {4'd5, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9};

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] load_hours;
		logic [5:0] load_minutes;
		logic [5:0] load_seconds;
		logic [4:0] now_hours;
		logic [5:0] now_minutes;
		logic [5:0] now_seconds;
	} cmd_t;

	typedef struct packed {
		logic [3:0] sec_ones;
		logic [2:0] sec_tens;
		logic [3:0] min_ones;
		logic [2:0] min_tens;
		logic [3:0] hour_ones;
		logic [2:0] hour_tens;
		logic       buzzer_on;
		logic       is_running;
	} disp_t;

	function automatic logic [4:0] sat_hours(input logic [4:0] v);
		return (v > MaxHours) ? MaxHours : v;
	endfunction

	function automatic logic [5:0] sat_min_sec(input logic [5:0] v);
		return (v > MaxMinSec) ? MaxMinSec : v;
	endfunction

	function automatic logic [16:0] to_secs(input logic [4:0] h, input logic [5:0] m,
			input logic [5:0] s);
		return 17'(17'(h) * 17'd3600) + 17'(17'(m) * 17'd60) + 17'(s);
	endfunction

	// 0..59 to {tens[2:0], ones[3:0]}
	function automatic logic [6:0] split_bcd(input logic [5:0] v);
		logic [2:0] tens;
		logic [5:0] base;
		if (v >= 6'd50) begin
			tens = 3'd5;
		end else if (v >= 6'd40) begin
			tens = 3'd4;
		end else if (v >= 6'd30) begin
			tens = 3'd3;
		end else if (v >= 6'd20) begin
			tens = 3'd2;
		end else if (v >= 6'd10) begin
			tens = 3'd1;
		end else begin
			tens = 3'd0;
		end
		base = 6'({tens, 3'b000}) + 6'({tens, 1'b0});
		return {tens, 4'(v - base)};
	endfunction

endpackage

FILE: hw/rtl/bcdt_if.sv
// Request and result channels of the BCD clock / timer / stopwatch.
// Depends on bcdt_pkg for the payload types.
interface bcdt_cmd_if;
	logic valid;
	logic ready;
	bcdt_pkg::cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bcdt_disp_if;
	logic valid;
	logic ready;
	bcdt_pkg::disp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/bcdt_engine.sv
// bcdt_engine: time digits, seconds count and flags, with the per-request
// next-state logic. Depends on bcdt_pkg.
module bcdt_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [1:0]          fn,
	input  bcdt_pkg::cmd_t      cmd,
	output bcdt_pkg::disp_t     view
);

	bcdt_pkg::digits_t digits_q, digits_n, up_d, down_d, clk_d, load_d;
	logic [16:0] rem_q, rem_n, rem_dec, rem_clk, lt, nt, alarm_gap;
	logic armed_q, armed_n, run_q, run_n, buzz_q, buzz_n;
	logic up_wrap, hour_carry;
	logic [7:0] hours_val;
	logic [4:0] lh, nh;
	logic [5:0] lm, ls, nm, ns;
	logic [6:0] sec_bcd, min_bcd, hour_bcd;

	always_comb begin : up_chain
		logic c;
		c = 1'b1;
		up_d = digits_q;
		for (int i = 0; i < bcdt_pkg::NumDigits; i++) begin
			if (c) begin
				if (digits_q[i] >= bcdt_pkg::DigitLimit[i]) begin
					up_d[i] = '0;
				end else begin
					up_d[i] = digits_q[i] + 4'd1;
					c = 1'b0;
				end
			end
		end
		up_wrap = c;
	end

	always_comb begin : down_chain
		logic b;
		b = (digits_q != '0);
		down_d = digits_q;
		for (int i = 0; i < bcdt_pkg::NumDigits; i++) begin
			if (b) begin
				if (digits_q[i] == 4'd0) begin
					down_d[i] = bcdt_pkg::DigitLimit[i];
				end else begin
					down_d[i] = digits_q[i] - 4'd1;
					b = 1'b0;
				end
			end
		end
	end

	assign hour_carry = (digits_q[0] == 4'd9) && (digits_q[1] >= 4'd5) &&
		(digits_q[2] >= 4'd9) && (digits_q[3] >= 4'd5);
	assign hours_val = 8'({up_d[5], 3'b000}) + 8'({up_d[5], 1'b0}) + 8'(up_d[4]);

	always_comb begin
		clk_d = up_d;
		if (hour_carry && hours_val >= 8'd24) begin
			clk_d[4] = '0;
			clk_d[5] = '0;
		end
	end

	assign rem_dec = (rem_q == '0) ? bcdt_pkg::SecsPerDay - 17'd1 : rem_q - 17'd1;
	assign rem_clk = (rem_dec >= bcdt_pkg::SecsPerDay) ? rem_dec - bcdt_pkg::SecsPerDay
		: rem_dec;

	assign lh = bcdt_pkg::sat_hours(cmd.load_hours);
	assign lm = bcdt_pkg::sat_min_sec(cmd.load_minutes);
	assign ls = bcdt_pkg::sat_min_sec(cmd.load_seconds);
	assign nh = bcdt_pkg::sat_hours(cmd.now_hours);
	assign nm = bcdt_pkg::sat_min_sec(cmd.now_minutes);
	assign ns = bcdt_pkg::sat_min_sec(cmd.now_seconds);
	assign lt = bcdt_pkg::to_secs(lh, lm, ls);
	assign nt = bcdt_pkg::to_secs(nh, nm, ns);
	// modulo 2^17 is exact here, the true distance is below one day
	assign alarm_gap = (lt >= nt) ? lt - nt : lt + bcdt_pkg::SecsPerDay - nt;

	always_comb begin
		if (fn == bcdt_pkg::FN_CLOCK) begin
			sec_bcd  = bcdt_pkg::split_bcd(ns);
			min_bcd  = bcdt_pkg::split_bcd(nm);
			hour_bcd = bcdt_pkg::split_bcd({1'b0, nh});
		end else begin
			sec_bcd  = bcdt_pkg::split_bcd(ls);
			min_bcd  = bcdt_pkg::split_bcd(lm);
			hour_bcd = bcdt_pkg::split_bcd({1'b0, lh});
		end
		load_d[0] = sec_bcd[3:0];
		load_d[1] = {1'b0, sec_bcd[6:4]};
		load_d[2] = min_bcd[3:0];
		load_d[3] = {1'b0, min_bcd[6:4]};
		load_d[4] = hour_bcd[3:0];
		load_d[5] = {1'b0, hour_bcd[6:4]};
	end

	always_comb begin
		digits_n = digits_q;
		rem_n    = rem_q;
		armed_n  = armed_q;
		run_n    = run_q;
		buzz_n   = buzz_q;
		case (cmd.mode)
			bcdt_pkg::MODE_TICK: begin
				if (run_q) begin
					case (fn)
						bcdt_pkg::FN_STOPWATCH: begin
							digits_n = up_d;
							if (up_wrap) begin
								run_n = 1'b0;
							end
						end
						bcdt_pkg::FN_TIMER: begin
							if (rem_q == '0) begin
								buzz_n = ~buzz_q;
							end else begin
								digits_n = down_d;
								rem_n = rem_q - 17'd1;
							end
						end
						bcdt_pkg::FN_CLOCK: begin
							digits_n = clk_d;
							rem_n = rem_clk;
							if (armed_q && rem_clk == '0) begin
								buzz_n = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			bcdt_pkg::MODE_LOAD: begin
				case (fn)
					bcdt_pkg::FN_CLOCK: begin
						digits_n = load_d;
						rem_n    = alarm_gap;
						armed_n  = 1'b1;
						run_n    = 1'b1;
						buzz_n   = (alarm_gap == '0);
					end
					bcdt_pkg::FN_STOPWATCH: begin
						digits_n = '0;
						rem_n    = '0;
						armed_n  = 1'b0;
						run_n    = 1'b1;
						buzz_n   = 1'b0;
					end
					bcdt_pkg::FN_TIMER: begin
						digits_n = load_d;
						rem_n    = lt;
						armed_n  = 1'b0;
						run_n    = 1'b1;
						buzz_n   = 1'b0;
					end
					default: ;
				endcase
			end
			bcdt_pkg::MODE_CLEAR: begin
				digits_n = '0;
				rem_n    = '0;
				armed_n  = 1'b0;
				run_n    = 1'b0;
				buzz_n   = 1'b0;
			end
			bcdt_pkg::MODE_RUN: begin
				run_n = ~run_q;
				if (fn == bcdt_pkg::FN_TIMER) begin
					buzz_n = 1'b0;
				end
			end
			bcdt_pkg::MODE_SILENCE: begin
				buzz_n = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			rem_q    <= '0;
			armed_q  <= 1'b0;
			run_q    <= 1'b0;
			buzz_q   <= 1'b0;
		end else if (en) begin
			digits_q <= digits_n;
			rem_q    <= rem_n;
			armed_q  <= armed_n;
			run_q    <= run_n;
			buzz_q   <= buzz_n;
		end
	end

	assign view.sec_ones   = digits_n[0];
	assign view.sec_tens   = digits_n[1][2:0];
	assign view.min_ones   = digits_n[2];
	assign view.min_tens   = digits_n[3][2:0];
	assign view.hour_ones  = digits_n[4];
	assign view.hour_tens  = digits_n[5][2:0];
	assign view.buzzer_on  = buzz_n;
	assign view.is_running = run_n;

endmodule

FILE: hw/rtl/bcd_clock_timer_stopwatch.sv
// BCD clock with alarm, countdown timer and stopwatch.
// Result path: the request is captured in the input register, then the result
// register is written as the state updates; a stalled result holds it.
// Throughput: one request per cycle unless stalled; single-pass state update.
// Reset (arst_n low) clears time, seconds count, flags and function select.
// Depends on bcdt_pkg, bcdt_if and bcdt_engine.
module bcd_clock_timer_stopwatch (
	input  logic               clk,
	input  logic               arst_n,
	bcdt_cmd_if.sink           cmd,
	bcdt_disp_if.source        disp,
	input  logic               wr_en,
	input  logic [1:0]         wr_data
);

	logic [1:0] fn_q;
	bcdt_pkg::cmd_t cmd_s1;
	logic vld_s1, vld_s2, advance;
	bcdt_pkg::disp_t view, res_s2;

	assign advance   = vld_s1 && (!vld_s2 || disp.ready);
	assign cmd.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q <= bcdt_pkg::FN_CLOCK;
		end else if (wr_en) begin
			fn_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
	end

	bcdt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.fn     (fn_q),
		.cmd    (cmd_s1),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (disp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= view;
		end
	end

	assign disp.valid = vld_s2;
	assign disp.data  = res_s2;

endmodule
